// File: rtl/core/wss_pkg.sv
// shared types, codes and constants of the windowed segment sender
`timescale 1ns / 1ps

package wss_pkg;

    localparam int WINDOW   = 8;
    localparam int CREDIT_W = $clog2(WINDOW + 1);
    localparam int SEQ_W    = 6;

    localparam logic [7:0] TX_SYN = 8'h40;
    localparam logic [7:0] TX_RST = 8'h80;

    typedef enum logic [1:0] {
        OP_START      = 2'd0,
        OP_TICK       = 2'd1,
        OP_RX         = 2'd2,
        OP_CLIENT_RST = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        RX_DATA_ACK = 2'd0,
        RX_SYN_ACK  = 2'd1,
        RX_RST      = 2'd2,
        RX_OTHER    = 2'd3
    } rx_type_t;

    typedef enum logic [1:0] {
        KIND_CTRL = 2'd0,
        KIND_DATA = 2'd1,
        KIND_DONE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_REPLY = 2'd1,
        ST_RESET    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SYN  = 2'd1,
        PH_SEND = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        SEL_SYN  = 2'd0,
        SEL_RST  = 2'd1,
        SEL_SEG  = 2'd2,
        SEL_DONE = 2'd3
    } out_sel_t;

    localparam logic CFG_MTU   = 1'b0;
    localparam logic CFG_RETRY = 1'b1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] length_bytes;
        logic [7:0]  rx_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic [15:0] seg_offset;
        logic [7:0]  seg_length;
        logic [1:0]  status;
        logic        last;
    } out_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic     load_in;
        logic     start;
        logic     enter_send;
        logic     reload;
        logic     dec_retry;
        logic     rx_apply;
        logic     self_rst;
        logic     seg_step;
        logic     to_idle;
        logic     emit;
        out_sel_t out_sel;
        status_t  out_status;
        logic     out_last;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        op_t      op;
        phase_t   phase;
        rx_type_t rx_type;
        logic     syn_acked;
        logic     data_acked;
        logic     peer_reset;
        logic     self_reset;
        logic     retries_zero;
        logic     credit_zero;
        logic     credit_one;
        logic     remaining_zero;
        logic     rem_after_zero;
        logic     slot_free;
    } stat_t;

endpackage

// File: rtl/core/wss_dp.sv
// datapath: transfer state, configuration, segment arithmetic and output register
`timescale 1ns / 1ps

module wss_dp
    import wss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  in_t        in_data,
    input  cmd_t       cmd,
    output stat_t      stat,
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_data
);

    logic [7:0]          mtu_reg;
    logic [7:0]          retry_limit_reg;
    logic [1:0]          op_reg;
    logic [15:0]         len_reg;
    logic [7:0]          rx_reg;
    phase_t              phase_reg,        phase_next;
    logic [7:0]          retries_reg,      retries_next;
    logic [CREDIT_W-1:0] credit_reg,       credit_next;
    logic [15:0]         cursor_reg,       cursor_next;
    logic [15:0]         remaining_reg,    remaining_next;
    logic [SEQ_W-1:0]    seq_reg,          seq_next;
    logic                syn_acked_reg,    syn_acked_next;
    logic                data_acked_reg,   data_acked_next;
    logic                peer_reset_reg,   peer_reset_next;
    logic                self_reset_reg,   self_reset_next;
    logic                out_valid_reg,    out_valid_next;
    out_t                out_reg,          out_next;

    logic [7:0]  mtu_eff;
    logic [7:0]  pay;
    logic [7:0]  seg_len;
    logic [15:0] rem_after;
    logic        slot_free;
    rx_type_t    rx_type;

    assign mtu_eff   = (mtu_reg < 8'd2) ? 8'd2 : mtu_reg;
    assign pay       = mtu_eff - 8'd1;
    assign seg_len   = (remaining_reg > {8'd0, pay}) ? pay : remaining_reg[7:0];
    assign rem_after = remaining_reg - {8'd0, seg_len};
    assign slot_free = !out_valid_reg || !out_stall;
    assign rx_type   = rx_type_t'(rx_reg[7:6]);

    always_comb
    begin
        stat.op             = op_t'(op_reg);
        stat.phase          = phase_reg;
        stat.rx_type        = rx_type;
        stat.syn_acked      = syn_acked_reg;
        stat.data_acked     = data_acked_reg;
        stat.peer_reset     = peer_reset_reg;
        stat.self_reset     = self_reset_reg;
        stat.retries_zero   = (retries_reg == 8'd0);
        stat.credit_zero    = (credit_reg == '0);
        stat.credit_one     = (credit_reg == CREDIT_W'(1));
        stat.remaining_zero = (remaining_reg == 16'd0);
        stat.rem_after_zero = (rem_after == 16'd0);
        stat.slot_free      = slot_free;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        retries_next    = retries_reg;
        credit_next     = credit_reg;
        cursor_next     = cursor_reg;
        remaining_next  = remaining_reg;
        seq_next        = seq_reg;
        syn_acked_next  = syn_acked_reg;
        data_acked_next = data_acked_reg;
        peer_reset_next = peer_reset_reg;
        self_reset_next = self_reset_reg;

        if (cmd.start)
        begin
            syn_acked_next  = 1'b0;
            data_acked_next = 1'b0;
            peer_reset_next = 1'b0;
            self_reset_next = 1'b0;
            credit_next     = CREDIT_W'(WINDOW);
            cursor_next     = 16'd0;
            remaining_next  = len_reg;
            seq_next        = '0;
            retries_next    = retry_limit_reg;
            phase_next      = PH_SYN;
        end
        if (cmd.enter_send)
        begin
            phase_next      = PH_SEND;
            retries_next    = retry_limit_reg;
            data_acked_next = 1'b0;
        end
        if (cmd.reload)
        begin
            retries_next    = retry_limit_reg;
            data_acked_next = 1'b0;
        end
        if (cmd.dec_retry)
        begin
            retries_next = retries_reg - 8'd1;
        end
        if (cmd.rx_apply)
        begin
            unique case (rx_type)
                RX_DATA_ACK:
                begin
                    if (credit_reg < CREDIT_W'(WINDOW))
                    begin
                        credit_next = credit_reg + CREDIT_W'(1);
                    end
                    data_acked_next = 1'b1;
                end
                RX_SYN_ACK:
                begin
                    syn_acked_next = 1'b1;
                end
                RX_RST:
                begin
                    if (!self_reset_reg)
                    begin
                        peer_reset_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.self_rst)
        begin
            self_reset_next = 1'b1;
            peer_reset_next = 1'b1;
        end
        if (cmd.seg_step)
        begin
            seq_next       = seq_reg + SEQ_W'(1);
            cursor_next    = cursor_reg + {8'd0, seg_len};
            remaining_next = rem_after;
            credit_next    = credit_reg - CREDIT_W'(1);
        end
        if (cmd.to_idle)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_comb
    begin
        out_next            = out_reg;
        out_next.kind       = KIND_CTRL;
        out_next.tx_byte    = 8'd0;
        out_next.seg_offset = 16'd0;
        out_next.seg_length = 8'd0;
        out_next.status     = ST_OK;
        out_next.last       = cmd.out_last;
        unique case (cmd.out_sel)
            SEL_SYN:
            begin
                out_next.tx_byte = TX_SYN;
            end
            SEL_RST:
            begin
                out_next.tx_byte = TX_RST;
            end
            SEL_SEG:
            begin
                out_next.kind       = KIND_DATA;
                out_next.tx_byte    = {{(8 - SEQ_W){1'b0}}, seq_reg};
                out_next.seg_offset = cursor_reg;
                out_next.seg_length = seg_len;
            end
            SEL_DONE:
            begin
                out_next.kind   = KIND_DONE;
                out_next.status = cmd.out_status;
            end
            default:
            begin
            end
        endcase
        if (!cmd.emit)
        begin
            out_next = out_reg;
        end
        out_valid_next = cmd.emit ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mtu_reg         <= 8'd20;
            retry_limit_reg <= 8'd3;
            phase_reg       <= PH_IDLE;
            retries_reg     <= 8'd0;
            credit_reg      <= CREDIT_W'(WINDOW);
            cursor_reg      <= 16'd0;
            remaining_reg   <= 16'd0;
            seq_reg         <= '0;
            syn_acked_reg   <= 1'b0;
            data_acked_reg  <= 1'b0;
            peer_reset_reg  <= 1'b0;
            self_reset_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_MTU)
            begin
                mtu_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_RETRY)
            begin
                retry_limit_reg <= cfg_data;
            end
            phase_reg      <= phase_next;
            retries_reg    <= retries_next;
            credit_reg     <= credit_next;
            cursor_reg     <= cursor_next;
            remaining_reg  <= remaining_next;
            seq_reg        <= seq_next;
            syn_acked_reg  <= syn_acked_next;
            data_acked_reg <= data_acked_next;
            peer_reset_reg <= peer_reset_next;
            self_reset_reg <= self_reset_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg  <= in_data.operation;
            len_reg <= in_data.length_bytes;
            rx_reg  <= in_data.rx_byte;
        end
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: rtl/core/wss_ctrl.sv
// controller: decodes each item and sequences the burst of segments
`timescale 1ns / 1ps

module wss_ctrl
    import wss_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_BURST  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   active;

    assign active   = (stat.phase == PH_SYN) || (stat.phase == PH_SEND);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // every action waits for a free output slot
                if (stat.slot_free)
                begin
                    state_next = S_IDLE;
                    unique case (stat.op)
                        OP_START:
                        begin
                            cmd.start    = 1'b1;
                            cmd.emit     = 1'b1;
                            cmd.out_sel  = SEL_SYN;
                            cmd.out_last = 1'b1;
                        end
                        OP_TICK:
                        begin
                            priority if (active && stat.peer_reset)
                            begin
                                cmd.emit       = 1'b1;
                                cmd.out_sel    = SEL_DONE;
                                cmd.out_status = ST_RESET;
                                cmd.out_last   = 1'b1;
                                cmd.to_idle    = 1'b1;
                            end
                            else if (active && (stat.phase == PH_SYN) && !stat.syn_acked
                                     && !stat.retries_zero)
                            begin
                                cmd.dec_retry = 1'b1;
                                cmd.emit      = 1'b1;
                                cmd.out_sel   = SEL_SYN;
                                cmd.out_last  = 1'b1;
                            end
                            else if (active && stat.retries_zero
                                     && !((stat.phase == PH_SYN) && stat.syn_acked)
                                     && !((stat.phase == PH_SEND) && stat.data_acked))
                            begin
                                cmd.emit       = 1'b1;
                                cmd.out_sel    = SEL_DONE;
                                cmd.out_status = ST_NO_REPLY;
                                cmd.out_last   = 1'b1;
                                cmd.to_idle    = 1'b1;
                            end
                            else if (active)
                            begin
                                // retry check passed: adjust budget, then burst if credit remains
                                if (stat.phase == PH_SYN)
                                begin
                                    cmd.enter_send = 1'b1;
                                end
                                else if (stat.data_acked)
                                begin
                                    cmd.reload = 1'b1;
                                end
                                else
                                begin
                                    cmd.dec_retry = 1'b1;
                                end
                                if (!stat.credit_zero)
                                begin
                                    state_next = S_BURST;
                                end
                                else if (stat.remaining_zero)
                                begin
                                    state_next = S_FINISH;
                                end
                            end
                            else
                            begin
                            end
                        end
                        OP_RX:
                        begin
                            if (active)
                            begin
                                cmd.rx_apply = 1'b1;
                                if (stat.rx_type == RX_RST && !stat.self_reset)
                                begin
                                    cmd.emit     = 1'b1;
                                    cmd.out_sel  = SEL_RST;
                                    cmd.out_last = 1'b1;
                                end
                            end
                        end
                        OP_CLIENT_RST:
                        begin
                            cmd.self_rst = 1'b1;
                            cmd.emit     = 1'b1;
                            cmd.out_sel  = SEL_RST;
                            cmd.out_last = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BURST:
            begin
                if (stat.slot_free)
                begin
                    cmd.seg_step = 1'b1;
                    cmd.emit     = 1'b1;
                    cmd.out_sel  = SEL_SEG;
                    if (stat.rem_after_zero)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (stat.credit_one)
                    begin
                        cmd.out_last = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
            end
            S_FINISH:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.out_sel    = SEL_DONE;
                    cmd.out_status = ST_OK;
                    cmd.out_last   = 1'b1;
                    cmd.to_idle    = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/windowed_segment_sender.sv
// top level of the windowed segment sender: controller plus datapath
`timescale 1ns / 1ps

// Client side of a credit-windowed transfer. A start item sends a SYN
// control byte and arms the transfer; each interval tick resends the SYN
// until a SYN-ACK has been received, then sends a burst of data segments
// (6-bit wrapping sequence header, offset, length up to mtu_bytes-1) while
// window credit remains. Received bytes return credit, flag the SYN-ACK or
// carry an RST, which is answered with an RST control byte unless the
// client has reset first. A completion item reports success, no reply or
// reset. Items are taken one at a time: an item is accepted in the idle
// state and decoded in the execute state, which waits for a free output
// slot; a tick that sends segments then passes through the burst state and,
// for a success completion, the finish state. During a burst the datapath
// emits one result per cycle into the output register; a stall on the
// output side holds the burst.
module windowed_segment_sender
    import wss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration: index 0 mtu_bytes, index 1 retry_limit
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    // input items
    input  logic       in_valid,
    output logic       in_stall,
    input  in_t        in_data,
    // result items
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_data
);

    // command and status between the two halves
    cmd_t  cmd;
    stat_t stat;

    // state machine: decode, burst sequencing, completion
    wss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // transfer state, configuration and the registered result slot
    wss_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: dv/windowed_segment_sender_test.sv
// self-checking testbench of the windowed segment sender
`timescale 1ns / 1ps

module windowed_segment_sender_test;
    import wss_pkg::*;

    localparam int RANDOM_ITEMS  = 96;
    localparam int PHASES        = 6;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int TIMEOUT_NS    = 4_000_000;

    // single-result rows whose outcome is plain from the protocol
    localparam out_t SYN_SENT      = '{KIND_CTRL, TX_SYN, 16'd0, 8'd0, ST_OK, 1'b1};
    localparam out_t RST_SENT      = '{KIND_CTRL, TX_RST, 16'd0, 8'd0, ST_OK, 1'b1};
    localparam out_t DONE_RESET    = '{KIND_DONE, 8'd0, 16'd0, 8'd0, ST_RESET, 1'b1};
    localparam out_t DONE_NO_REPLY = '{KIND_DONE, 8'd0, 16'd0, 8'd0, ST_NO_REPLY, 1'b1};

    typedef struct packed {
        in_t  item;
        logic typed;
        out_t want;
    } dir_row_t;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_EVERY_THIRD
    } stall_mode_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_index = CFG_MTU;
    logic [7:0] cfg_data  = 8'd0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    in_t        in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    out_t       out_data;

    // own copy of the sender state, starting from its reset values
    logic [7:0]          mtu_reg      = 8'd20;
    logic [7:0]          retry_reg    = 8'd3;
    phase_t              ph           = PH_IDLE;
    logic [7:0]          retries_left = 8'd0;
    logic [CREDIT_W-1:0] credit       = CREDIT_W'(WINDOW);
    logic [15:0]         cursor       = 16'd0;
    logic [15:0]         remaining    = 16'd0;
    logic [SEQ_W-1:0]    seq_no       = '0;
    logic                syn_acked    = 1'b0;
    logic                data_acked   = 1'b0;
    logic                peer_rst     = 1'b0;
    logic                self_rst     = 1'b0;

    out_t     step_tx[$];      // results of the item being predicted
    out_t     expected_tx[$];  // results still to come from the block
    dir_row_t dir_rows[$];

    int          mismatches = 0;
    int          items_done = 0;
    int          item_goal  = 0;
    int          burst_left = 0;
    bit          hold_req   = 1'b0;
    int          hold_left  = 0;
    int          pat_left   = 0;
    int          pat_tick   = 0;
    stall_mode_t pat_mode   = STALL_NONE;

    windowed_segment_sender u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // prediction of the transmitted items
    // ---------------------------------------------------------------

    function automatic void add_tx(kind_t k, logic [7:0] tx, logic [15:0] off,
                                   logic [7:0] len, status_t st);
        out_t r;
        r.kind       = k;
        r.tx_byte    = tx;
        r.seg_offset = off;
        r.seg_length = len;
        r.status     = st;
        r.last       = 1'b0;
        step_tx.push_back(r);
    endfunction

    function automatic void finish_tx(status_t st);
        add_tx(KIND_DONE, 8'd0, 16'd0, 8'd0, st);
        ph = PH_IDLE;
    endfunction

    // segments while credit lasts; zero credit sends no segment at all
    function automatic void send_burst();
        logic [15:0] pay;
        logic [15:0] seg;
        pay = ((mtu_reg < 8'd2) ? 16'd2 : {8'd0, mtu_reg}) - 16'd1;
        if (credit != 0)
        begin
            do
            begin
                seg = (remaining > pay) ? pay : remaining;
                add_tx(KIND_DATA, {2'b00, seq_no}, cursor, seg[7:0], ST_OK);
                seq_no    = seq_no + 1'b1;
                cursor    = cursor + seg;
                remaining = remaining - seg;
                credit    = credit - 1'b1;
            end while (credit != 0 && remaining != 0);
        end
        // nothing left over: success follows in the same tick
        if (remaining == 0)
            finish_tx(ST_OK);
    endfunction

    function automatic void predict_tx(in_t item);
        logic active;
        out_t tail;
        step_tx.delete();
        active = (ph == PH_SYN) || (ph == PH_SEND);
        case (op_t'(item.operation))
            OP_START:
            begin
                // a start abandons whatever was in flight and clears every flag
                syn_acked    = 1'b0;
                data_acked   = 1'b0;
                peer_rst     = 1'b0;
                self_rst     = 1'b0;
                credit       = CREDIT_W'(WINDOW);
                cursor       = 16'd0;
                remaining    = item.length_bytes;
                seq_no       = '0;
                retries_left = retry_reg;
                ph           = PH_SYN;
                add_tx(KIND_CTRL, TX_SYN, 16'd0, 8'd0, ST_OK);
            end
            OP_TICK:
            begin
                if (active && peer_rst)
                    finish_tx(ST_RESET);
                else if (ph == PH_SYN)
                begin
                    if (syn_acked)
                    begin
                        ph           = PH_SEND;
                        retries_left = retry_reg;
                        data_acked   = 1'b0;
                        send_burst();
                    end
                    else if (retries_left == 0)
                        finish_tx(ST_NO_REPLY);
                    else
                    begin
                        retries_left = retries_left - 1'b1;
                        add_tx(KIND_CTRL, TX_SYN, 16'd0, 8'd0, ST_OK);
                    end
                end
                else if (ph == PH_SEND)
                begin
                    if (data_acked)
                    begin
                        retries_left = retry_reg;
                        data_acked   = 1'b0;
                        send_burst();
                    end
                    else if (retries_left == 0)
                        finish_tx(ST_NO_REPLY);
                    else
                    begin
                        retries_left = retries_left - 1'b1;
                        send_burst();
                    end
                end
            end
            OP_RX:
            begin
                if (active)
                begin
                    case (rx_type_t'(item.rx_byte[7:6]))
                        RX_DATA_ACK:
                        begin
                            if (credit < WINDOW)
                                credit = credit + 1'b1;
                            data_acked = 1'b1;
                        end
                        RX_SYN_ACK:
                            syn_acked = 1'b1;
                        RX_RST:
                        begin
                            // after our own reset this is the peer's acknowledgement
                            if (!self_rst)
                            begin
                                peer_rst = 1'b1;
                                add_tx(KIND_CTRL, TX_RST, 16'd0, 8'd0, ST_OK);
                            end
                        end
                        default:
                            ;
                    endcase
                end
            end
            OP_CLIENT_RST:
            begin
                self_rst = 1'b1;
                peer_rst = 1'b1;
                add_tx(KIND_CTRL, TX_RST, 16'd0, 8'd0, ST_OK);
            end
        endcase
        if (step_tx.size() > 0)
        begin
            tail      = step_tx.pop_back();
            tail.last = 1'b1;
            step_tx.push_back(tail);
        end
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    // offers one item in bursts with random gaps, and predicts it once taken
    task automatic offer(input in_t item, input logic typed, input out_t want);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_tx(item);
        items_done++;
        if (typed)
            expected_tx.push_back(want);
        else
            foreach (step_tx[i])
                expected_tx.push_back(step_tx[i]);
    endtask

    task automatic offer_op(input op_t op, input logic [15:0] len, input logic [7:0] rx);
        in_t item;
        item.operation    = op;
        item.length_bytes = len;
        item.rx_byte      = rx;
        offer(item, 1'b0, '0);
    endtask

    // sender stops until every result is back and the block has gone quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_tx.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_limits(input logic [7:0] mtu, input logic [7:0] retries);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MTU;
        cfg_data  <= mtu;
        @(negedge clk);
        cfg_index <= CFG_RETRY;
        cfg_data  <= retries;
        @(negedge clk);
        cfg_we <= 1'b0;
        mtu_reg   = mtu;
        retry_reg = retries;
    endtask

    // one handshake then a run of ticks with credit returned in between
    task automatic run_transfer();
        int pay;
        int syn_ticks;
        int acks;
        int steps;
        pay = mtu_reg - 1;
        if ($urandom_range(0, 7) == 0)
            offer_op(OP_START, 16'($urandom), 8'($urandom));
        else
            offer_op(OP_START, 16'($urandom_range(0, pay * 12)), 8'($urandom));
        // a few unanswered syn items first, sometimes enough to give up
        syn_ticks = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
        repeat (syn_ticks) offer_op(OP_TICK, 16'($urandom), 8'($urandom));
        offer_op(OP_RX, 16'($urandom), {RX_SYN_ACK, 6'($urandom)});
        steps = 0;
        while ((ph == PH_SYN || ph == PH_SEND) && steps < 12 && items_done < item_goal)
        begin
            offer_op(OP_TICK, 16'($urandom), 8'($urandom));
            // mostly a little credit back, now and then more than the window
            acks = ($urandom_range(0, 7) == 0) ? $urandom_range(0, WINDOW + 2)
                                                : $urandom_range(0, 3);
            repeat (acks) offer_op(OP_RX, 16'($urandom), {RX_DATA_ACK, 6'($urandom)});
            if ($urandom_range(0, 11) == 0)
                offer_op(op_t'($urandom_range(OP_RX, OP_CLIENT_RST)), 16'($urandom),
                         {rx_type_t'($urandom_range(RX_RST, RX_OTHER)), 6'($urandom)});
            steps++;
        end
    endtask

    // ---------------------------------------------------------------
    // output side
    // ---------------------------------------------------------------

    // own stall pattern, plus one long hold-off when asked for
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            if (pat_left == 0)
            begin
                pat_left = $urandom_range(4, 40);
                pat_mode = stall_mode_t'($urandom_range(STALL_NONE, STALL_EVERY_THIRD));
            end
            pat_left--;
            pat_tick++;
            case (pat_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= (pat_tick % 3 == 0);
            endcase
        end
    end

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_tx.size() == 0)
            begin
                $error("result item with nothing expected: %h", out_data);
                mismatches++;
            end
            else
            begin
                want = expected_tx.pop_front();
                check_field("kind", 16'(want.kind), 16'(out_data.kind));
                check_field("tx_byte", 16'(want.tx_byte), 16'(out_data.tx_byte));
                check_field("seg_offset", want.seg_offset, out_data.seg_offset);
                check_field("seg_length", 16'(want.seg_length), 16'(out_data.seg_length));
                check_field("status", 16'(want.status), 16'(out_data.status));
                check_field("last", 16'(want.last), 16'(out_data.last));
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    function automatic void add_row(op_t op, logic [15:0] len, logic [7:0] rx,
                                    logic typed, out_t want);
        dir_row_t r;
        r.item.operation    = op;
        r.item.length_bytes = len;
        r.item.rx_byte      = rx;
        r.typed             = typed;
        r.want              = want;
        dir_rows.push_back(r);
    endfunction

    initial
    begin
        int mtu_set[PHASES];
        int retry_set[PHASES];

        // directed part, run with the register values left by reset
        // ticks and received bytes while idle are dropped
        add_row(OP_TICK, 16'd0, 8'h00, 1'b0, '0);
        // zero-length transfer: one syn resend, then one empty segment and success
        add_row(OP_START, 16'd0, 8'h00, 1'b1, SYN_SENT);
        add_row(OP_TICK, 16'd0, 8'h00, 1'b1, SYN_SENT);
        add_row(OP_RX, 16'd0, {RX_SYN_ACK, 6'h3f}, 1'b0, '0);
        add_row(OP_TICK, 16'd0, 8'h00, 1'b0, '0);
        // longest transfer drains the whole window in one burst
        add_row(OP_START, 16'hffff, 8'hff, 1'b1, SYN_SENT);
        add_row(OP_RX, 16'hffff, {RX_SYN_ACK, 6'h00}, 1'b0, '0);
        add_row(OP_TICK, 16'hffff, 8'h00, 1'b0, '0);
        // no credit left: tick spends a retry and sends nothing
        add_row(OP_TICK, 16'd0, 8'h00, 1'b0, '0);
        add_row(OP_RX, 16'd0, {RX_OTHER, 6'h3f}, 1'b0, '0);
        add_row(OP_RX, 16'd0, {RX_DATA_ACK, 6'h00}, 1'b0, '0);
        add_row(OP_RX, 16'd0, {RX_DATA_ACK, 6'h3f}, 1'b0, '0);
        add_row(OP_TICK, 16'd0, 8'h00, 1'b0, '0);
        // peer reset is answered each time, then the next tick ends the transfer
        add_row(OP_RX, 16'd0, {RX_RST, 6'h00}, 1'b1, RST_SENT);
        add_row(OP_RX, 16'd0, {RX_RST, 6'h3f}, 1'b1, RST_SENT);
        add_row(OP_TICK, 16'd0, 8'h00, 1'b1, DONE_RESET);
        // client reset works even while idle
        add_row(OP_CLIENT_RST, 16'd0, 8'h00, 1'b1, RST_SENT);
        // client reset mid-transfer: the peer's rst is its acknowledgement
        add_row(OP_START, 16'd1, 8'h00, 1'b1, SYN_SENT);
        add_row(OP_CLIENT_RST, 16'hffff, 8'hff, 1'b1, RST_SENT);
        add_row(OP_RX, 16'd0, {RX_RST, 6'h15}, 1'b0, '0);
        add_row(OP_TICK, 16'd0, 8'h00, 1'b1, DONE_RESET);
        // no syn-ack ever: retries run out
        add_row(OP_START, 16'd5, 8'h00, 1'b1, SYN_SENT);
        add_row(OP_TICK, 16'd0, 8'h00, 1'b1, SYN_SENT);
        add_row(OP_TICK, 16'd0, 8'h00, 1'b1, SYN_SENT);
        add_row(OP_TICK, 16'd0, 8'h00, 1'b1, SYN_SENT);
        add_row(OP_TICK, 16'd0, 8'h00, 1'b1, DONE_NO_REPLY);

        // register settings per random phase, extremes first
        mtu_set   = '{2, 255, $urandom_range(2, 255), 2, 255, $urandom_range(2, 40)};
        retry_set = '{0, 255, $urandom_range(0, 255), 255, 0, $urandom_range(0, 4)};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        items_done = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            set_limits(8'(mtu_set[p]), 8'(retry_set[p]));
            // long hold-off at the receiver while items keep coming
            if (p == 2)
                hold_req = 1'b1;
            item_goal = items_done + RANDOM_ITEMS / PHASES;
            while (items_done < item_goal)
            begin
                if ($urandom_range(0, 9) == 0)
                    offer_op(op_t'($urandom_range(OP_START, OP_CLIENT_RST)),
                             16'($urandom), 8'($urandom));
                else
                    run_transfer();
                if ($urandom_range(0, 7) == 0)
                    settle();
            end
        end

        settle();
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/wss_pkg.sv
rtl/core/wss_dp.sv
rtl/core/wss_ctrl.sv
rtl/core/windowed_segment_sender.sv
dv/windowed_segment_sender_test.sv
